// File: rtl/e2c_pkg.sv
// ----------------------------------------------------------------------------
// e2c_pkg
// Shared types, constants and calendar tables of the seconds-to-date converter.
// ----------------------------------------------------------------------------
package e2c_pkg;

	localparam logic [31:0] LocalOffset    = 32'd28800;
	localparam logic [11:0] EpochYear      = 12'd1970;
	localparam logic [11:0] YlBase         = 12'd1900;
	// two-digit year folds back to 100 from 2100 on
	localparam logic [11:0] YlBaseLate     = 12'd2000;
	localparam logic [11:0] YlLateYear     = 12'd2100;
	localparam logic [11:0] YearBaseReset  = 12'd2000;
	// only century inside the reachable range 1970..2106 that is not a leap year
	localparam logic [11:0] NonLeapCentury = 12'd2100;
	localparam logic [15:0] DaysYear       = 16'd365;
	localparam logic [15:0] DaysLeapYear   = 16'd366;
	localparam logic [15:0] DaysShortMonth = 16'd28;
	localparam logic [3:0]  MonthsYear     = 4'd12;
	localparam logic [3:0]  LastMonth      = 4'd11;
	localparam logic [3:0]  MonthMar       = 4'd2;
	localparam logic        DivQuotStep    = 1'b1;
	localparam logic        DivRemStep     = 1'b0;
	// reciprocals rounded up: 2^35/675, 2^21/225, 2^14/15, 2^12/7
	localparam logic [25:0] RecipDay       = 26'd50903317;
	localparam logic [13:0] RecipHour      = 14'd9321;
	localparam logic [10:0] RecipMin       = 11'd1093;
	localparam logic [9:0]  RecipWeek      = 10'd586;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DAY,
		ST_HOUR,
		ST_MIN,
		ST_YEAR,
		ST_MONTH,
		ST_WLOAD,
		ST_WDAY,
		ST_FINISH
	} e2c_state_t;

	typedef enum logic [1:0] {
		DIV_DAY,
		DIV_HOUR,
		DIV_MIN,
		DIV_WEEK
	} div_sel_t;

	typedef struct packed {
		logic       load;
		logic       div_en;
		div_sel_t   sel;
		logic       step;
		logic       year_en;
		logic       month_en;
		logic       wday_load;
		logic       finish;
	} e2c_cmd_t;

	typedef struct packed {
		logic year_done;
		logic month_done;
	} e2c_status_t;

	function automatic logic leap_year(input logic [11:0] y);
		return (y[1:0] == 2'd0) && (y != NonLeapCentury);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
		logic [4:0] len;
		len = 5'd31;
		if (m == 4'd1) begin
			len = lp ? 5'd29 : 5'd28;
		end else if (m inside {4'd3, 4'd5, 4'd8, 4'd10}) begin
			len = 5'd30;
		end
		return len;
	endfunction

	function automatic logic [2:0] week_adj(input logic [3:0] m);
		logic [2:0] a;
		case (m)
			4'd0:    a = 3'd0;
			4'd1:    a = 3'd3;
			4'd2:    a = 3'd3;
			4'd3:    a = 3'd6;
			4'd4:    a = 3'd1;
			4'd5:    a = 3'd4;
			4'd6:    a = 3'd6;
			4'd7:    a = 3'd2;
			4'd8:    a = 3'd5;
			4'd9:    a = 3'd0;
			4'd10:   a = 3'd3;
			4'd11:   a = 3'd5;
			default: a = 3'd0;
		endcase
		return a;
	endfunction

	function automatic logic [16:0] divisor_of(input div_sel_t sel);
		logic [16:0] d;
		case (sel)
			DIV_DAY:  d = 17'd86400;
			DIV_HOUR: d = 17'd3600;
			DIV_MIN:  d = 17'd60;
			DIV_WEEK: d = 17'd7;
			default:  d = 17'd7;
		endcase
		return d;
	endfunction

endpackage

// File: rtl/epoch_seconds_to_calendar_date.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date
// Converts UTC seconds since 1970 to local (UTC+8) date, time and weekday.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive utc_seconds and raise start; the transaction is taken at a
//   clock edge with start high and busy low. busy stays high while a
//   conversion runs.
//   Output: done is high for exactly one cycle with year, month, day, hour,
//   minute, second and weekday valid; the receiver cannot stall, and the
//   result ports keep their value until the next done.
//   Each division by a constant takes a reciprocal multiply step and a
//   remainder step (days, hours, minutes, weekday); the year loop steps
//   through the years past 1970, one year per cycle.
//   A new transaction may be accepted in the cycle done is high.
//   Configuration: year_base is written through cfg_valid/cfg_data, always
//   ready; write it only while idle.
//   Reset: arst_n clears the sequencer to idle, done low, year_base to 2000.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date import e2c_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] utc_seconds,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data,
	output logic        done,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic [2:0]  weekday
);

	e2c_cmd_t    cmd;
	e2c_status_t status;

	assign cfg_ready = 1'b1;

	e2c_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	e2c_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.utc_seconds (utc_seconds),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_data    (cfg_data),
		.year        (year),
		.month       (month),
		.day         (day),
		.hour        (hour),
		.minute      (minute),
		.second      (second),
		.weekday     (weekday),
		.done        (done)
	);

	// result strobe only comes once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("transaction accepted but not busy");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && day <= 5'd31))
		else $error("date out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hour < 5'd24 && minute < 6'd60 && second < 6'd60 && weekday != 3'd0))
		else $error("time or weekday out of range");

endmodule

// File: rtl/e2c_ctrl.sv
// ----------------------------------------------------------------------------
// e2c_ctrl
// Sequencer of the converter: steps the divider, the year and month loops and
// the weekday reduction, one operation per cycle.
// ----------------------------------------------------------------------------
module e2c_ctrl import e2c_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  e2c_status_t status,
	output e2c_cmd_t    cmd,
	output logic        busy
);

	e2c_state_t state_q, state_d;
	logic       step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= DivRemStep;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DAY;
					step_d  = DivQuotStep;
				end
			end
			ST_DAY: begin
				if (step_q == DivRemStep) begin
					state_d = ST_HOUR;
					step_d  = DivQuotStep;
				end else begin
					step_d = DivRemStep;
				end
			end
			ST_HOUR: begin
				if (step_q == DivRemStep) begin
					state_d = ST_MIN;
					step_d  = DivQuotStep;
				end else begin
					step_d = DivRemStep;
				end
			end
			ST_MIN: begin
				if (step_q == DivRemStep) begin
					state_d = ST_YEAR;
				end else begin
					step_d = DivRemStep;
				end
			end
			ST_YEAR: begin
				if (status.year_done) begin
					state_d = ST_MONTH;
				end
			end
			ST_MONTH: begin
				if (status.month_done) begin
					state_d = ST_WLOAD;
				end
			end
			ST_WLOAD: begin
				state_d = ST_WDAY;
				step_d  = DivQuotStep;
			end
			ST_WDAY: begin
				if (step_q == DivRemStep) begin
					state_d = ST_FINISH;
				end else begin
					step_d = DivRemStep;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.sel  = DIV_DAY;
		cmd.step = step_q;
		busy     = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_DAY: begin
				cmd.div_en = 1'b1;
				cmd.sel    = DIV_DAY;
			end
			ST_HOUR: begin
				cmd.div_en = 1'b1;
				cmd.sel    = DIV_HOUR;
			end
			ST_MIN: begin
				cmd.div_en = 1'b1;
				cmd.sel    = DIV_MIN;
			end
			ST_YEAR: begin
				cmd.year_en = 1'b1;
			end
			ST_MONTH: begin
				cmd.month_en = 1'b1;
			end
			ST_WLOAD: begin
				cmd.wday_load = 1'b1;
			end
			ST_WDAY: begin
				cmd.div_en = 1'b1;
				cmd.sel    = DIV_WEEK;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/e2c_dp.sv
// ----------------------------------------------------------------------------
// e2c_dp
// Datapath: reciprocal-multiply divider by constants, year and month counters,
// weekday sum and the result registers.
// ----------------------------------------------------------------------------
module e2c_dp import e2c_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  e2c_cmd_t    cmd,
	output e2c_status_t status,
	input  logic [31:0] utc_seconds,
	input  logic        cfg_we,
	input  logic [11:0] cfg_data,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic [2:0]  weekday,
	output logic        done
);

	logic [31:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] days_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;
	logic [11:0] year_q;
	logic [3:0]  mon_q;
	logic [11:0] year_base_q;
	logic        done_q;
	logic [11:0] year_out_q;
	logic [3:0]  month_out_q;
	logic [4:0]  day_out_q;
	logic [4:0]  hour_out_q;
	logic [5:0]  minute_out_q;
	logic [5:0]  second_out_q;
	logic [2:0]  weekday_out_q;

	logic [50:0] prod_day;
	logic [26:0] prod_hour;
	logic [20:0] prod_min;
	logic [18:0] prod_week;
	logic [15:0] quo;
	logic [31:0] qmul;
	logic        lp;
	logic [4:0]  mlen;
	logic [3:0]  mfin;
	logic [7:0]  yl;
	logic [9:0]  wsum;

	// low power-of-two factor of each divisor is shifted out first
	assign prod_day  = 51'(rem_q[31:7]) * 51'(RecipDay);
	assign prod_hour = 27'(rem_q[16:4]) * 27'(RecipHour);
	assign prod_min  = 21'(rem_q[11:2]) * 21'(RecipMin);
	assign prod_week = 19'(rem_q[8:0]) * 19'(RecipWeek);

	always_comb begin
		case (cmd.sel)
			DIV_DAY:  quo = prod_day[50:35];
			DIV_HOUR: quo = {10'd0, prod_hour[26:21]};
			DIV_MIN:  quo = {9'd0, prod_min[20:14]};
			DIV_WEEK: quo = {9'd0, prod_week[18:12]};
			default:  quo = {9'd0, prod_week[18:12]};
		endcase
	end

	assign qmul = 32'(quo_q) * {15'd0, divisor_of(cmd.sel)};
	assign lp   = leap_year(year_q);
	assign mlen = month_len(mon_q, lp);
	assign mfin = (mon_q > LastMonth) ? LastMonth : mon_q;
	assign yl   = (year_q >= YlLateYear) ? 8'(year_q - YlBaseLate) : 8'(year_q - YlBase);
	assign wsum = 10'(yl) + 10'(yl >> 2) + 10'(days_q[4:0]) + 10'd1 + 10'(week_adj(mfin))
		- (((yl[1:0] == 2'd0) && (mfin < MonthMar)) ? 10'd1 : 10'd0);

	assign status.year_done  = (days_q < DaysYear) || (lp && (days_q < DaysLeapYear));
	assign status.month_done = (mon_q >= MonthsYear) || (days_q < DaysShortMonth)
		|| (days_q < {11'd0, mlen});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_base_q <= YearBaseReset;
			done_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				year_base_q <= cfg_data;
			end
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q    <= utc_seconds + LocalOffset;
			days_q   <= 16'd0;
			hour_q   <= 5'd0;
			minute_q <= 6'd0;
			year_q   <= EpochYear;
			mon_q    <= 4'd0;
		end
		if (cmd.div_en) begin
			if (cmd.step == DivQuotStep) begin
				quo_q <= quo;
				case (cmd.sel)
					DIV_DAY:  days_q <= quo;
					DIV_HOUR: hour_q <= quo[4:0];
					DIV_MIN:  minute_q <= quo[5:0];
					default:  ;
				endcase
			end else begin
				rem_q <= rem_q - qmul;
			end
		end
		if (cmd.year_en && !status.year_done) begin
			days_q <= days_q - (lp ? DaysLeapYear : DaysYear);
			year_q <= year_q + 12'd1;
		end
		if (cmd.month_en && !status.month_done) begin
			days_q <= days_q - {11'd0, mlen};
			mon_q  <= mon_q + 4'd1;
		end
		if (cmd.wday_load) begin
			second_q <= rem_q[5:0];
			rem_q    <= {22'd0, wsum};
		end
		if (cmd.finish) begin
			year_out_q    <= (year_q > year_base_q) ? year_q : 12'd0;
			month_out_q   <= mfin + 4'd1;
			day_out_q     <= days_q[4:0] + 5'd1;
			hour_out_q    <= hour_q;
			minute_out_q  <= minute_q;
			second_out_q  <= second_q;
			weekday_out_q <= (rem_q[2:0] == 3'd0) ? 3'd7 : rem_q[2:0];
		end
	end

	assign year    = year_out_q;
	assign month   = month_out_q;
	assign day     = day_out_q;
	assign hour    = hour_out_q;
	assign minute  = minute_out_q;
	assign second  = second_out_q;
	assign weekday = weekday_out_q;
	assign done    = done_q;

endmodule
